FILE: rtl/core/calendar_month_grid_assert.svh
// assertion macros for the month grid checker
// needs signals named clock and reset in the scope of use
`ifndef CALENDAR_MONTH_GRID_ASSERT_SVH
`define CALENDAR_MONTH_GRID_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CMG_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("calendar_month_grid: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define CMG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("calendar_month_grid: next-cycle check failed");

`endif

FILE: rtl/core/cmg_pkg.sv
// shared types, constants and helper functions of the month grid block
// no dependencies
package cmg_pkg;

   // field widths
   localparam int MonthW = 4;
   localparam int YearW  = 14;
   localparam int DayW   = 5;
   localparam int RowW   = 3;
   localparam int ColW   = 3;
   localparam int WdayW  = 3;
   localparam int CsrW   = 14;
   localparam int CsrIdxW = 2;

   // configuration register indexes
   localparam logic [CsrIdxW-1:0] CSR_WEEK_START      = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_HIGHLIGHT_DAY   = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_HIGHLIGHT_MONTH = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_HIGHLIGHT_YEAR  = 2'd3;

   // reset values
   localparam logic [WdayW-1:0]  WEEK_START_RESET = 3'd1;
   localparam logic [DayW-1:0]   HL_DAY_RESET     = 5'd0;
   localparam logic [MonthW-1:0] HL_MONTH_RESET   = 4'd0;
   localparam logic [YearW-1:0]  HL_YEAR_RESET    = 14'd0;

   // year offset keeps the year positive after the january/february shift
   localparam logic [14:0] YEAR_OFFSET = 15'd400;
   // floor(z / 100) = (z * RECIP_100) >> RECIP_SHIFT for every z below 2^15
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;
   localparam logic [6:0]  LAST_COLUMN = 7'd6;

   typedef struct packed {
      logic [WdayW-1:0]  week_start;
      logic [DayW-1:0]   hl_day;
      logic [MonthW-1:0] hl_month;
      logic [YearW-1:0]  hl_year;
   } cfg_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;    // capture request and week start
      logic divide;  // year by 100
      logic sum;     // leap test, month length, congruence sum
      logic reduce;  // sum modulo 7, first column
      logic step;    // advance to next day
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic month_ok;
      logic last_day;
   } status_type;

   // days in a month
   function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                  input logic leap);
      logic [DayW-1:0] d;
      unique case (m)
         4'd2:                      d = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
         default:                   d = 5'd31;
      endcase
      return d;
   endfunction

   // floor(13 * (mm + 1) / 5) with january and february as months 13 and 14
   function automatic logic [5:0] zeller_term(input logic [MonthW-1:0] m);
      logic [5:0] t;
      unique case (m)
         4'd1:    t = 6'd36;
         4'd2:    t = 6'd39;
         4'd3:    t = 6'd10;
         4'd4:    t = 6'd13;
         4'd5:    t = 6'd15;
         4'd6:    t = 6'd18;
         4'd7:    t = 6'd20;
         4'd8:    t = 6'd23;
         4'd9:    t = 6'd26;
         4'd10:   t = 6'd28;
         4'd11:   t = 6'd31;
         4'd12:   t = 6'd33;
         default: t = 6'd0;
      endcase
      return t;
   endfunction

   // modulo 7 of an 11-bit value by folding powers of two that are 1 mod 7
   function automatic logic [2:0] mod7(input logic [10:0] x);
      logic [9:0] s1;
      logic [6:0] s2;
      logic [4:0] s3;
      logic [4:0] s4;
      s1 = {8'd0, x[10:9]} + {1'b0, x[8:0]};
      s2 = {3'd0, s1[9:6]} + {1'b0, s1[5:0]};
      s3 = {1'b0, s2[6:3]} + {2'd0, s2[2:0]};
      s4 = (s3 >= 5'd7) ? s3 - 5'd7 : s3;
      s4 = (s4 >= 5'd7) ? s4 - 5'd7 : s4;
      return s4[2:0];
   endfunction

endpackage

FILE: rtl/core/cmg_csr.sv
// configuration registers of the month grid block
// depends on cmg_pkg
module cmg_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [cmg_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [cmg_pkg::CsrW-1:0]     csr_wdata,
   output cmg_pkg::cfg_type             cfg
);

   cmg_pkg::cfg_type cfg_ff;
   cmg_pkg::cfg_type cfg_in;

   // write decode, each register keeps its low bits
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            cmg_pkg::CSR_WEEK_START:      cfg_in.week_start = csr_wdata[2:0];
            cmg_pkg::CSR_HIGHLIGHT_DAY:   cfg_in.hl_day     = csr_wdata[4:0];
            cmg_pkg::CSR_HIGHLIGHT_MONTH: cfg_in.hl_month   = csr_wdata[3:0];
            cmg_pkg::CSR_HIGHLIGHT_YEAR:  cfg_in.hl_year    = csr_wdata[13:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.week_start <= cmg_pkg::WEEK_START_RESET;
         cfg_ff.hl_day     <= cmg_pkg::HL_DAY_RESET;
         cfg_ff.hl_month   <= cmg_pkg::HL_MONTH_RESET;
         cfg_ff.hl_year    <= cmg_pkg::HL_YEAR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/cmg_ctrl.sv
// controller state machine of the month grid block
// depends on cmg_pkg; drives the datapath through cmd_type
module cmg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  cmg_pkg::status_type  status,
   output cmg_pkg::cmd_type     cmd,
   output logic                 busy,
   output logic                 strobe
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SUM,
      ST_REDUCE,
      ST_RUN
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start && status.month_ok) state_in = ST_DIVIDE;
         ST_DIVIDE: state_in = ST_SUM;
         ST_SUM:    state_in = ST_REDUCE;
         ST_REDUCE: state_in = ST_RUN;
         ST_RUN:    if (status.last_day) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // command decode
   assign cmd.load   = (state_ff == ST_IDLE) && start;
   assign cmd.divide = (state_ff == ST_DIVIDE);
   assign cmd.sum    = (state_ff == ST_SUM);
   assign cmd.reduce = (state_ff == ST_REDUCE);
   assign cmd.step   = (state_ff == ST_RUN);

   assign busy   = (state_ff != ST_IDLE);
   assign strobe = (state_ff == ST_RUN);

endmodule

FILE: rtl/core/cmg_datapath.sv
// datapath of the month grid block: weekday of the 1st, month length, day walk
// depends on cmg_pkg; sequenced by cmg_ctrl
module cmg_datapath (
   input  logic                        clock,
   input  cmg_pkg::cmd_type            cmd,
   input  cmg_pkg::cfg_type            cfg,
   input  logic [cmg_pkg::MonthW-1:0]  req_month,
   input  logic [cmg_pkg::YearW-1:0]   req_year,
   output cmg_pkg::status_type         status,
   output logic [cmg_pkg::DayW-1:0]    day_number,
   output logic [cmg_pkg::RowW-1:0]    week_row,
   output logic [cmg_pkg::ColW-1:0]    grid_column,
   output logic                        highlighted,
   output logic                        last_of_month
);

   logic [cmg_pkg::MonthW-1:0] month_ff;
   logic [cmg_pkg::YearW-1:0]  year_ff;
   logic [cmg_pkg::WdayW-1:0]  ws_ff;
   logic [7:0]                 cent_ff;
   logic [10:0]                sum_ff;
   logic [cmg_pkg::DayW-1:0]   ndays_ff;
   logic                       hl_my_ff;
   logic [cmg_pkg::DayW-1:0]   day_ff;
   logic [cmg_pkg::RowW-1:0]   row_ff;
   logic [cmg_pkg::ColW-1:0]   col_ff;

   logic [14:0] z;
   logic [27:0] prod;
   logic [14:0] rem_full;
   logic [6:0]  rz;
   logic        leap;
   logic [7:0]  cent;
   logic [6:0]  yr;
   logic [10:0] sum_in;
   logic [2:0]  first;
   logic [3:0]  col_raw;
   logic [2:0]  col0;

   // shifted year and its quotient by 100 through a reciprocal
   assign z    = {1'b0, year_ff} + cmg_pkg::YEAR_OFFSET;
   assign prod = {13'd0, z} * {15'd0, cmg_pkg::RECIP_100};

   // remainder by 100 and gregorian leap test
   assign rem_full = z - {7'd0, cent_ff} * 15'd100;
   assign rz       = rem_full[6:0];
   assign leap     = ((year_ff[1:0] == 2'd0) && (rz != 7'd0)) ||
                     ((rz == 7'd0) && (cent_ff[1:0] == 2'd0));

   // january and february belong to the previous year
   always_comb begin
      cent = cent_ff;
      yr   = rz;
      if (month_ff < 4'd3) begin
         if (rz == 7'd0) begin
            cent = cent_ff - 8'd1;
            yr   = 7'd99;
         end else begin
            yr   = rz - 7'd1;
         end
      end
   end

   assign sum_in = {5'd0, cmg_pkg::zeller_term(month_ff)}
                 + {5'd0, cent[7:2]}
                 + ({3'd0, cent} * 11'd5)
                 + {4'd0, yr}
                 + {6'd0, yr[6:2]};

   // weekday of the 1st and its column
   assign first   = cmg_pkg::mod7(sum_ff);
   assign col_raw = {1'b0, first} + 4'd7 - {1'b0, ws_ff};
   assign col0    = (col_raw >= 4'd7) ? col_raw[2:0] - 3'd7 : col_raw[2:0];

   // request capture and setup registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         month_ff <= req_month;
         year_ff  <= req_year;
         ws_ff    <= (cfg.week_start == 3'd7) ? 3'd0 : cfg.week_start;
      end
      if (cmd.divide) begin
         cent_ff <= prod[cmg_pkg::RECIP_SHIFT+7:cmg_pkg::RECIP_SHIFT];
      end
      if (cmd.sum) begin
         sum_ff   <= sum_in;
         ndays_ff <= cmg_pkg::month_days(month_ff, leap);
         hl_my_ff <= (month_ff == cfg.hl_month) && (year_ff == cfg.hl_year);
      end
   end

   // day walk: a new row after the last column
   always_ff @(posedge clock) begin
      if (cmd.reduce) begin
         day_ff <= 5'd1;
         row_ff <= '0;
         col_ff <= col0;
      end else if (cmd.step) begin
         day_ff <= day_ff + 5'd1;
         if ({4'd0, col_ff} == cmg_pkg::LAST_COLUMN) begin
            col_ff <= '0;
            row_ff <= row_ff + 3'd1;
         end else begin
            col_ff <= col_ff + 3'd1;
         end
      end
   end

   assign status.month_ok = (req_month >= 4'd1) && (req_month <= 4'd12);
   assign status.last_day = (day_ff == ndays_ff);

   assign day_number    = day_ff;
   assign week_row      = row_ff;
   assign grid_column   = col_ff;
   assign highlighted   = hl_my_ff && (day_ff == cfg.hl_day);
   assign last_of_month = (day_ff == ndays_ff);

endmodule

FILE: rtl/core/calendar_month_grid.sv
// Month grid generator. A request (month, year) is accepted when start is high and
// busy is low. Setup steps follow in order (year divided by 100, congruence sum and
// month length, sum reduced modulo 7), then one result per day of the month is
// driven on consecutive cycles with rsp_strobe high; busy stays high until the last
// day, so the next request is accepted only after it. Results cannot be held off:
// each one is valid for exactly its strobe cycle. A month outside 1..12 is taken
// and gives no results; busy stays low. Configuration may be written only while
// busy is low.
// top level of the month grid block
// depends on cmg_pkg, cmg_csr, cmg_ctrl and cmg_datapath
module calendar_month_grid (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [cmg_pkg::MonthW-1:0]   req_month,
   input  logic [cmg_pkg::YearW-1:0]    req_year,
   output logic                         rsp_strobe,
   output logic [cmg_pkg::DayW-1:0]     rsp_day_number,
   output logic [cmg_pkg::RowW-1:0]     rsp_week_row,
   output logic [cmg_pkg::ColW-1:0]     rsp_grid_column,
   output logic                         rsp_highlighted,
   output logic                         rsp_last_of_month,
   input  logic                         csr_we,
   input  logic [cmg_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [cmg_pkg::CsrW-1:0]     csr_wdata
);

   cmg_pkg::cfg_type    cfg;
   cmg_pkg::cmd_type    cmd;
   cmg_pkg::status_type status;

   // configuration registers
   cmg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer
   cmg_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .strobe (rsp_strobe)
   );

   // arithmetic and day walk
   cmg_datapath u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .cfg           (cfg),
      .req_month     (req_month),
      .req_year      (req_year),
      .status        (status),
      .day_number    (rsp_day_number),
      .week_row      (rsp_week_row),
      .grid_column   (rsp_grid_column),
      .highlighted   (rsp_highlighted),
      .last_of_month (rsp_last_of_month)
   );

endmodule

FILE: rtl/core/cmg_checker.sv
// port-level checks of the month grid block, bound to the top level
// depends on calendar_month_grid_assert.svh and cmg_pkg
`include "calendar_month_grid_assert.svh"

module cmg_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [cmg_pkg::MonthW-1:0]  req_month,
   input  logic                        rsp_strobe,
   input  logic [cmg_pkg::DayW-1:0]    rsp_day_number,
   input  logic                        rsp_last_of_month
);

   logic accept_valid;

   // a request with a real month starts a transfer sequence
   assign accept_valid = start && !busy && (req_month >= 4'd1) && (req_month <= 4'd12);

   // results only appear while the block is busy
   `CMG_ASSERT_SAME(a_strobe_busy, rsp_strobe, busy)
   // an accepted month makes the block busy
   `CMG_ASSERT_NEXT(a_accept_busy, accept_valid, busy)
   // days follow on back to back until the last one
   `CMG_ASSERT_NEXT(a_days_run, rsp_strobe && !rsp_last_of_month,
                    rsp_strobe && (rsp_day_number == $past(rsp_day_number) + 5'd1))
   // the last day ends the sequence
   `CMG_ASSERT_NEXT(a_last_ends, rsp_strobe && rsp_last_of_month, !rsp_strobe && !busy)

endmodule

bind calendar_month_grid cmg_checker u_cmg_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_month         (req_month),
   .rsp_strobe        (rsp_strobe),
   .rsp_day_number    (rsp_day_number),
   .rsp_last_of_month (rsp_last_of_month)
);
